### hdl/orwa_pkg.sv
`timescale 1ns / 1ps

package orwa_pkg;

  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 10;
  localparam int BAND_DIV    = 10;

  localparam int DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int STEP_MAX = (WINDOW > SAMPLE_BITS) ? WINDOW : SAMPLE_BITS;
  localparam int STEP_W   = $clog2(STEP_MAX);

  // Reciprocal constants for exact division of an n-bit value by a constant d:
  // q = (x * ceil(2^(n+l) / d)) >> (n+l), with l = clog2(d).
  localparam int MEAN_SH = SUM_W + $clog2(WINDOW);
  localparam longint unsigned MEAN_MUL =
      ((64'd1 << MEAN_SH) + WINDOW - 1) / WINDOW;
  localparam int BAND_SH = SAMPLE_BITS + $clog2(BAND_DIV);
  localparam longint unsigned BAND_MUL =
      ((64'd1 << BAND_SH) + BAND_DIV - 1) / BAND_DIV;

  typedef struct packed {
    logic accept;
    logic calc_mean;
    logic calc_band;
    logic scan;
    logic div_init;
    logic div_step;
    logic load_out;
  } orwa_cmd_t;

  typedef struct packed {
    logic out_free;
  } orwa_status_t;

endpackage

### hdl/orwa_ctrl.sv
`timescale 1ns / 1ps

module orwa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  orwa_pkg::orwa_status_t status,
  output orwa_pkg::orwa_cmd_t    cmd
);
  import orwa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MEAN   = 7'b0000010,
    S_BAND   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_PREP   = 7'b0010000,
    S_DIVIDE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.calc_mean = 1'b1;
        state_nxt     = S_BAND;
      end
      S_BAND: begin
        cmd.calc_band = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(WINDOW - 1)) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(SAMPLE_BITS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### hdl/orwa_datapath.sv
`timescale 1ns / 1ps

module orwa_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [orwa_pkg::SAMPLE_BITS-1:0] sample,
  input  orwa_pkg::orwa_cmd_t           cmd,
  output orwa_pkg::orwa_status_t        status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [orwa_pkg::SAMPLE_BITS-1:0] out_value
);
  import orwa_pkg::*;

  localparam logic [SUM_W:0]       MeanMul = MEAN_MUL[SUM_W:0];
  localparam logic [SAMPLE_BITS:0] BandMul = BAND_MUL[SAMPLE_BITS:0];

  logic [SAMPLE_BITS-1:0] win_r [WINDOW];
  logic [SAMPLE_BITS-1:0] win_nxt [WINDOW];
  logic [SUM_W-1:0]       total_r;
  logic [SAMPLE_BITS-1:0] mean_r;
  logic [SAMPLE_BITS-1:0] band_r;
  logic [SUM_W-1:0]       kept_sum_r;
  logic [CNT_W-1:0]       kept_cnt_r;
  logic [SUM_W-1:0]       rem_r;
  logic [SUM_W-1:0]       dvs_r;
  logic [SAMPLE_BITS-1:0] quo_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_value_r;

  logic [2*SUM_W:0]         mean_prod;
  logic [2*SAMPLE_BITS:0]   band_prod;
  logic [SAMPLE_BITS:0]     upper;
  logic [SAMPLE_BITS-1:0]   lower;
  logic [SAMPLE_BITS-1:0]   head;
  logic                     in_band;

  assign mean_prod = (2*SUM_W+1)'(total_r) * (2*SUM_W+1)'(MeanMul);
  assign band_prod = (2*SAMPLE_BITS+1)'(mean_r) * (2*SAMPLE_BITS+1)'(BandMul);

  assign head    = win_r[0];
  assign upper   = {1'b0, mean_r} + {1'b0, band_r};
  assign lower   = mean_r - band_r;
  assign in_band = ({1'b0, head} < upper) && (head > lower);

  // The window rotates during the scan so that every entry passes the head
  // once and the order is restored after a full turn.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (cmd.accept || cmd.scan) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[WINDOW-1] = cmd.accept ? sample : win_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
      total_r <= '0;
    end else begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= win_nxt[i];
      end
      if (cmd.accept) begin
        total_r <= total_r + SUM_W'(sample) - SUM_W'(win_r[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_mean) begin
      mean_r <= mean_prod[MEAN_SH +: SAMPLE_BITS];
    end
    if (cmd.calc_band) begin
      band_r     <= SAMPLE_BITS'(band_prod >> BAND_SH);
      kept_sum_r <= '0;
      kept_cnt_r <= '0;
    end
    if (cmd.scan && in_band) begin
      kept_sum_r <= kept_sum_r + SUM_W'(head);
      kept_cnt_r <= kept_cnt_r + 1'b1;
    end
    if (cmd.div_init) begin
      rem_r <= kept_sum_r;
      dvs_r <= SUM_W'(kept_cnt_r) << (SAMPLE_BITS - 1);
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rem_r - dvs_r;
        quo_r <= {quo_r[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[SAMPLE_BITS-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.load_out) begin
      out_value_r <= (kept_cnt_r == '0) ? '0 : quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;

endmodule

### hdl/outlier_rejecting_window_average_core.sv
`timescale 1ns / 1ps

// Outlier-rejecting window average.
// The input stream carries one unsigned sample per item in in_tdata (low bits);
// the output stream carries one filtered value per item in out_tdata.
// Each sample enters a window of the last WINDOW samples. The block takes the
// window mean, a band of mean/10 around it, and returns the mean of the
// samples lying strictly inside the band, or zero when none do.
// After an input is accepted, the block computes the mean and the band with
// two multiplies, scans the window entry by entry, sets up the divider, runs
// the bit-serial divider one result bit at a time and loads the output
// register. Items are handled one at a time: the next item is accepted only
// after the previous result has been loaded into the output register.
// in_tready is high only while the controller is idle. A result waits in the
// output register until taken; the next item is accepted meanwhile, and its
// own result is held back until the register is free.
// Reset clears the window to zeros and empties the output register.
module outlier_rejecting_window_average_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [orwa_pkg::DATA_W-1:0] in_tdata,   // sample
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [orwa_pkg::DATA_W-1:0] out_tdata   // filtered
);
  import orwa_pkg::*;

  orwa_cmd_t              cmd;
  orwa_status_t           status;
  logic [SAMPLE_BITS-1:0] out_value;

  orwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  orwa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_value)
  );

  assign out_tdata = DATA_W'(out_value);

endmodule

### tb/window_average_checker.sv
`timescale 1ns / 1ps

module window_average_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [orwa_pkg::DATA_W-1:0] in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [orwa_pkg::DATA_W-1:0] out_tdata,
  output int                          fail_count,
  output int                          pending
);
  import orwa_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  sample_t window_q [WINDOW];
  sample_t filtered_q [$];
  int mismatch_count = 0;
  int result_count = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Shifts the new sample into the window and returns the mean of the samples
  // that lie strictly inside the band of mean/10 around the window mean.
  function automatic sample_t shift_and_filter(input sample_t fresh);
    logic [SUM_BITS-1:0] total;
    logic [SUM_BITS-1:0] kept_sum;
    sample_t mean;
    sample_t band;
    logic [SAMPLE_BITS:0] upper;
    logic [SAMPLE_BITS:0] lower;
    int unsigned kept;
    for (int k = 0; k < WINDOW - 1; k++) window_q[k] = window_q[k + 1];
    window_q[WINDOW - 1] = fresh;
    total = '0;
    kept_sum = '0;
    kept = 0;
    foreach (window_q[k]) total += window_q[k];
    mean = sample_t'(total / WINDOW);
    band = sample_t'(mean / BAND_DIV);
    upper = mean + band;
    lower = mean - band;
    foreach (window_q[k]) begin
      if (window_q[k] < upper && window_q[k] > lower) begin
        kept_sum += window_q[k];
        kept++;
      end
    end
    if (kept == 0) return '0;
    return sample_t'(kept_sum / kept);
  endfunction

  always @(posedge clk) begin : watch
    sample_t want;
    if (!rst_n) begin
      foreach (window_q[k]) window_q[k] = '0;
      filtered_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result %0d arrived with none expected, got %0d",
                     $time, result_count, out_tdata[SAMPLE_BITS-1:0]);
          mismatch_count++;
        end else begin
          want = filtered_q.pop_front();
          if (out_tdata[SAMPLE_BITS-1:0] !== want) begin
            if (mismatch_count < 10)
              $display("%0t: result %0d filtered: expected %0d, got %0d",
                       $time, result_count, want, out_tdata[SAMPLE_BITS-1:0]);
            mismatch_count++;
          end
        end
        result_count++;
      end
      if (in_tvalid && in_tready)
        filtered_q.push_back(shift_and_filter(in_tdata[SAMPLE_BITS-1:0]));
    end
    fail_count <= mismatch_count;
    pending <= filtered_q.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import orwa_pkg::*;

  localparam int PHASE_ITEMS = 500;
  localparam int LONG_HOLD = 300;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [DATA_W-1:0] in_tdata = '0;
  logic out_tready = 1'b0;
  logic in_tready;
  logic out_tvalid;
  logic [DATA_W-1:0] out_tdata;

  int tx_pct = 0;
  int rx_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int fail_count;
  int pending;

  always #5 clk = ~clk;

  outlier_rejecting_window_average_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  window_average_checker filter_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_pct);
    end
  end

  task automatic send_sample(input sample_t value);
    while ($urandom_range(99) < tx_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= DATA_W'(value);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Mostly clusters around a level with occasional outliers, so that the band
  // keeps a varying subset of the window; the other scenes cover uniform
  // noise, samples up to 20, near-full-scale samples and small/large mixes.
  function automatic sample_t draw_sample(input int scene, input int level);
    int spread;
    int v;
    spread = level / 16 + 2;
    case (scene)
      6: v = $urandom_range(1023);
      7: v = $urandom_range(20);
      8: v = $urandom_range(1023, 1000);
      9: v = ($urandom_range(3) == 0) ? int'($urandom_range(1023)) : int'($urandom_range(12));
      default: begin
        if ($urandom_range(7) == 0) v = $urandom_range(1023);
        else v = level + int'($urandom_range(2 * spread)) - spread;
      end
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return sample_t'(v);
  endfunction

  initial begin : stimulus
    int directed [24] = '{0, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023,
                          1023, 500, 0, 1023, 1, 2, 4, 8, 16, 32, 64, 128, 256, 512};
    int tx_table [4] = '{0, 82, 0, 26};
    int rx_table [4] = '{0, 0, 82, 26};
    int scene;
    int level;
    scene = 0;
    level = 512;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_sample(sample_t'(directed[i]));
    for (int stage = 0; stage < 4; stage++) begin
      tx_pct = tx_table[stage];
      rx_pct <= rx_table[stage];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 16 == 0) begin
          scene = $urandom_range(9);
          level = $urandom_range(1023);
        end
        send_sample(draw_sample(scene, level));
      end
      tx_pct = 0;
      hold_requests <= hold_requests + 1;
      repeat (8) send_sample(draw_sample(6, 0));
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hdl/orwa_pkg.sv
hdl/orwa_ctrl.sv
hdl/orwa_datapath.sv
hdl/outlier_rejecting_window_average_core.sv
tb/window_average_checker.sv
tb/testbench.sv
